### rtl/rgb555_pixel_blender_top_defines.svh
// Assertion macros for the rgb555 pixel blender.
`ifndef RGB555_PIXEL_BLENDER_TOP_DEFINES_SVH
`define RGB555_PIXEL_BLENDER_TOP_DEFINES_SVH

// Same-cycle check, clocked on clk_i, off during reset.
`define RPB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Next-cycle check: antecedent implies consequent in the next cycle.
`define RPB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rpb_pkg.sv
// Types and constants shared by the rgb555 pixel blender modules.
package rpb_pkg;

  localparam int unsigned ChanW    = 5;
  localparam int unsigned PixW     = 16;
  localparam int unsigned ShadeW   = 24;
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 24;

  localparam logic [PixW-1:0] SemiFlag = 16'h8000;

  typedef enum logic [1:0] {
    ALPHA_AVG = 2'd0,
    ALPHA_ADD = 2'd1,
    ALPHA_SUB = 2'd2,
    ALPHA_QTR = 2'd3
  } alpha_mode_e;

  // Input item without the byte padding, lowest field last.
  typedef struct packed {
    alpha_mode_e        alpha_mode;
    logic               semi_trans;
    logic               modulate;
    logic               textured;
    logic [PixW-1:0]    dest_pixel;
    logic [ShadeW-1:0]  shade_color;
    logic [PixW-1:0]    texel;
  } rpb_item_t;

  localparam int unsigned ItemW = $bits(rpb_item_t);

  typedef struct packed {
    logic [OutDataW-PixW-2:0] pad;
    logic                     write_enable;
    logic [PixW-1:0]          pixel_out;
  } rpb_res_t;

endpackage

### rtl/rpb_src.sv
// Source color selection: raw texel, shade-modulated texel, flat shade, or zero when neither textured nor modulated.
module rpb_src (
  input  logic [rpb_pkg::PixW-1:0]   texel_i,
  input  logic [rpb_pkg::ShadeW-1:0] shade_color_i,
  input  logic                       textured_i,
  input  logic                       modulate_i,
  output logic [rpb_pkg::PixW-1:0]   src_o
);
  import rpb_pkg::*;

  // (c << 3) * shade / 128, saturated at 255, top 5 bits kept.
  function automatic logic [ChanW-1:0] chan_mod(input logic [ChanW-1:0] c,
                                                input logic [7:0] s);
    logic [15:0] prod;
    prod = {8'd0, c, 3'd0} * {8'd0, s};
    chan_mod = prod[15] ? {ChanW{1'b1}} : prod[14:10];
  endfunction

  logic [PixW-1:0] mod_texel;
  logic [PixW-1:0] flat_shade;

  assign mod_texel = SemiFlag
                   | {1'b0, chan_mod(texel_i[14:10], shade_color_i[23:16]), 10'd0}
                   | {6'd0, chan_mod(texel_i[9:5], shade_color_i[15:8]), 5'd0}
                   | {11'd0, chan_mod(texel_i[4:0], shade_color_i[7:0])};

  assign flat_shade = {1'b1, shade_color_i[23:19], shade_color_i[15:11],
                       shade_color_i[7:3]};

  always_comb begin
    priority if (textured_i) begin
      src_o = (modulate_i && (texel_i != '0)) ? mod_texel : texel_i;
    end else if (modulate_i) begin
      src_o = flat_shade;
    end else begin
      src_o = '0;
    end
  end

endmodule

### rtl/rpb_blend.sv
// Semi-transparency blend of the source color over the destination pixel.
module rpb_blend (
  input  logic [rpb_pkg::PixW-1:0] src_i,
  input  logic [rpb_pkg::PixW-1:0] dest_pixel_i,
  input  logic                     semi_trans_i,
  input  rpb_pkg::alpha_mode_e     alpha_mode_i,
  output logic [rpb_pkg::PixW-1:0] pixel_o
);
  import rpb_pkg::*;

  function automatic logic [ChanW-1:0] chan_blend(input logic [ChanW-1:0] s,
                                                  input logic [ChanW-1:0] d,
                                                  input alpha_mode_e m);
    logic [ChanW:0] sum;
    logic [ChanW:0] dif;
    logic [ChanW:0] qtr;
    sum = {1'b0, d} + {1'b0, s};
    dif = {1'b0, d} - {1'b0, s};
    qtr = {1'b0, d} + {3'd0, s[4:2]};
    unique case (m)
      ALPHA_AVG: chan_blend = {1'b0, d[4:1]} + {1'b0, s[4:1]};
      ALPHA_ADD: chan_blend = sum[ChanW] ? {ChanW{1'b1}} : sum[ChanW-1:0];
      ALPHA_SUB: chan_blend = dif[ChanW] ? '0 : dif[ChanW-1:0];
      ALPHA_QTR: chan_blend = qtr[ChanW] ? {ChanW{1'b1}} : qtr[ChanW-1:0];
      default:   chan_blend = '0;
    endcase
  endfunction

  logic [PixW-1:0] mixed;

  assign mixed = {1'b1,
                  chan_blend(src_i[14:10], dest_pixel_i[14:10], alpha_mode_i),
                  chan_blend(src_i[9:5], dest_pixel_i[9:5], alpha_mode_i),
                  chan_blend(src_i[4:0], dest_pixel_i[4:0], alpha_mode_i)};

  always_comb begin
    priority if (!semi_trans_i) begin
      pixel_o = src_i;
    end else if (src_i == '0) begin
      pixel_o = dest_pixel_i;
    end else if (!src_i[15]) begin
      pixel_o = src_i;
    end else begin
      pixel_o = mixed;
    end
  end

endmodule

### rtl/rgb555_pixel_blender_top.sv
// Top level of the rgb555 pixel blender: input register, color logic, result register.
// Takes one item per clock while the output is not held back, and gives one result per item.
// An accepted item is held in the input register. The source-select and blend logic runs
// between that register and the result register, so a result is registered once more before
// it is presented. Both registers advance together while the output is taken or empty.
// While a finished result waits, the input stays ready only as long as the input register
// is empty.
module rgb555_pixel_blender_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // texel[15:0], shade_color[39:16], dest_pixel[55:40], textured[56],
  // modulate[57], semi_trans[58], alpha_mode[60:59], zero[63:61]
  input  logic [rpb_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // pixel_out[15:0], write_enable[16], zero[23:17]
  output logic [rpb_pkg::OutDataW-1:0]  m_axis_tdata_o
);
  import rpb_pkg::*;

  `include "rgb555_pixel_blender_top_defines.svh"

  logic      in_valid_q;
  rpb_item_t in_item_q;
  rpb_item_t in_item_d;
  logic      out_valid_q;
  rpb_res_t  out_res_q;
  rpb_res_t  out_res_d;
  logic      out_adv;
  logic      in_adv;
  logic      in_acc;
  logic [PixW-1:0] src;
  logic [PixW-1:0] pixel;

  assign out_adv = !out_valid_q || m_axis_tready_i;
  assign in_adv  = !in_valid_q || out_adv;
  assign in_acc  = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = in_adv;
  assign in_item_d       = rpb_item_t'(s_axis_tdata_i[ItemW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_adv) begin
        in_valid_q <= s_axis_tvalid_i;
      end
      if (out_adv) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_item_q <= in_item_d;
    end
    if (out_adv && in_valid_q) begin
      out_res_q <= out_res_d;
    end
  end

  rpb_src u_src (
    .texel_i       (in_item_q.texel),
    .shade_color_i (in_item_q.shade_color),
    .textured_i    (in_item_q.textured),
    .modulate_i    (in_item_q.modulate),
    .src_o         (src)
  );

  rpb_blend u_blend (
    .src_i         (src),
    .dest_pixel_i  (in_item_q.dest_pixel),
    .semi_trans_i  (in_item_q.semi_trans),
    .alpha_mode_i  (in_item_q.alpha_mode),
    .pixel_o       (pixel)
  );

  always_comb begin
    out_res_d              = '0;
    out_res_d.pixel_out    = pixel;
    out_res_d.write_enable = (pixel != '0);
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_res_q;

  `RPB_ASSERT(a_we_matches_pixel,
              !out_valid_q || (out_res_q.write_enable == (out_res_q.pixel_out != '0)),
              "write enable disagrees with pixel")
  `RPB_ASSERT(a_no_accept_when_full, !(in_valid_q && out_valid_q && !m_axis_tready_i)
              || !s_axis_tready_o, "input accepted while both stages are blocked")
  `RPB_ASSERT_NEXT(a_accept_fills_stage, in_acc, in_valid_q,
                   "accepted item missing from input register")
  `RPB_ASSERT_NEXT(a_stall_keeps_item, in_valid_q && !out_adv, in_valid_q,
                   "stalled item dropped from input register")

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the rgb555 pixel blender: directed table, then random fragments.
module testbench;
  import rpb_pkg::*;

  localparam int unsigned NumRand    = 500;
  localparam int unsigned QuietTail  = 100;
  localparam int unsigned HoldAt     = 60;
  localparam int unsigned HoldCycles = 60;
  localparam int unsigned StallLimit = 2000;

  typedef struct {
    rpb_item_t   frag;
    bit          typed;
    logic [15:0] pix;
  } frag_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;

  rpb_res_t    pixel_q[$];
  frag_row_t   frag_rows[$];
  int unsigned err_cnt = 0;
  int unsigned stall_cnt = 0;
  bit          hold_req = 1'b0;
  bit          hold_on = 1'b0;
  bit          quiet_on = 1'b0;

  always #10 clk_i = ~clk_i;

  rgb555_pixel_blender_top i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  function automatic logic [4:0] shade_chan(logic [4:0] c, logic [7:0] s);
    int unsigned v;
    v = ((int'(c) << 3) * int'(s)) / 128;
    if (v > 255) v = 255;
    return v[7:3];
  endfunction

  function automatic logic [4:0] mix_chan(logic [4:0] s, logic [4:0] d, alpha_mode_e m);
    int unsigned sv, dv, o;
    sv = s;
    dv = d;
    case (m)
      ALPHA_AVG: o = dv / 2 + sv / 2;
      ALPHA_ADD: o = (dv + sv > 31) ? 31 : dv + sv;
      ALPHA_SUB: o = (dv < sv) ? 0 : dv - sv;
      default:   o = (dv + sv / 4 > 31) ? 31 : dv + sv / 4;
    endcase
    return o[4:0];
  endfunction

  function automatic rpb_res_t blend_pixel(rpb_item_t f);
    logic [15:0] src, pix;
    rpb_res_t    r;
    if (f.textured) begin
      src = f.texel;
      if (f.modulate && f.texel != '0) begin
        src = {1'b1, shade_chan(f.texel[14:10], f.shade_color[23:16]),
               shade_chan(f.texel[9:5], f.shade_color[15:8]),
               shade_chan(f.texel[4:0], f.shade_color[7:0])};
      end
    end else if (f.modulate) begin
      src = {1'b1, f.shade_color[23:19], f.shade_color[15:11], f.shade_color[7:3]};
    end else begin
      src = '0;
    end
    pix = src;
    if (f.semi_trans) begin
      if (src == '0) begin
        pix = f.dest_pixel;
      end else if (src[15]) begin
        pix = {1'b1, mix_chan(src[14:10], f.dest_pixel[14:10], f.alpha_mode),
               mix_chan(src[9:5], f.dest_pixel[9:5], f.alpha_mode),
               mix_chan(src[4:0], f.dest_pixel[4:0], f.alpha_mode)};
      end
    end
    r = '0;
    r.pixel_out = pix;
    r.write_enable = (pix != '0);
    return r;
  endfunction

  function automatic void add_row(bit tex, bit modu, bit semi, alpha_mode_e m,
                                  logic [15:0] texel, logic [23:0] shade,
                                  logic [15:0] dest, bit typed, logic [15:0] pix);
    frag_row_t row;
    row.frag.texel       = texel;
    row.frag.shade_color = shade;
    row.frag.dest_pixel  = dest;
    row.frag.textured    = tex;
    row.frag.modulate    = modu;
    row.frag.semi_trans  = semi;
    row.frag.alpha_mode  = m;
    row.typed            = typed;
    row.pix              = pix;
    frag_rows.push_back(row);
  endfunction

  function automatic logic [15:0] rand_color();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'($urandom_range(1, 16'h7fff));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic rpb_item_t rand_frag();
    rpb_item_t f;
    f.texel       = rand_color();
    f.dest_pixel  = rand_color();
    case ($urandom_range(0, 7))
      0:       f.shade_color = 24'h000000;
      1:       f.shade_color = 24'hffffff;
      default: f.shade_color = 24'($urandom);
    endcase
    f.textured    = 1'($urandom_range(0, 1));
    f.modulate    = 1'($urandom_range(0, 1));
    f.semi_trans  = 1'($urandom_range(0, 1));
    f.alpha_mode  = alpha_mode_e'($urandom_range(0, 3));
    return f;
  endfunction

  task automatic push_frag(input rpb_item_t f, input rpb_res_t want, input bit gaps);
    int unsigned n;
    if (gaps && !hold_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 5);
      s_axis_tvalid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {{(InDataW - ItemW){1'b0}}, f};
    do @(posedge clk_i); while (!s_axis_tready_o);
    pixel_q.push_back(want);
  endtask

  // Sink side: random backpressure bursts, plus one long hold on request.
  initial begin
    int unsigned n;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_on = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_on  = 1'b0;
        hold_req = 1'b0;
        m_axis_tready_i <= 1'b1;
      end else if (!quiet_on && s_axis_tvalid_i && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 5);
        m_axis_tready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    rpb_res_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = rpb_res_t'(m_axis_tdata_o);
      if (pixel_q.size() == 0) begin
        $error("unexpected result pixel_out=%h", got.pixel_out);
        err_cnt++;
      end else begin
        want = pixel_q.pop_front();
        if (got.pixel_out !== want.pixel_out) begin
          $error("pixel_out: expected %h, got %h", want.pixel_out, got.pixel_out);
          err_cnt++;
        end
        if (got.write_enable !== want.write_enable) begin
          $error("write_enable: expected %b, got %b", want.write_enable, got.write_enable);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= StallLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    rpb_res_t  want;
    rpb_item_t f;
    // tex, mod, semi, mode, texel, shade, dest, typed, pixel
    add_row(0, 0, 0, ALPHA_AVG, 16'h0000, 24'h000000, 16'h0000, 1, 16'h0000);
    add_row(0, 1, 0, ALPHA_AVG, 16'h0000, 24'hffffff, 16'h0000, 1, 16'hffff);
    add_row(0, 1, 0, ALPHA_ADD, 16'hffff, 24'h000000, 16'hffff, 1, 16'h8000);
    add_row(1, 0, 0, ALPHA_AVG, 16'hffff, 24'h000000, 16'h0000, 1, 16'hffff);
    add_row(1, 0, 0, ALPHA_SUB, 16'h0000, 24'hffffff, 16'hffff, 1, 16'h0000);
    // transparent texel stays zero under modulation
    add_row(1, 1, 0, ALPHA_AVG, 16'h0000, 24'hffffff, 16'hffff, 1, 16'h0000);
    add_row(1, 1, 0, ALPHA_AVG, 16'h7fff, 24'hffffff, 16'h0000, 1, 16'hffff);
    add_row(1, 1, 0, ALPHA_AVG, 16'h7fff, 24'h404040, 16'h0000, 1, 16'hbdef);
    add_row(1, 1, 0, ALPHA_ADD, 16'h0001, 24'h000001, 16'h0000, 1, 16'h8000);
    add_row(1, 1, 0, ALPHA_QTR, 16'h4210, 24'h808080, 16'h1234, 0, 16'h0000);
    // zero source keeps destination
    add_row(0, 0, 1, ALPHA_AVG, 16'h0000, 24'h000000, 16'habcd, 1, 16'habcd);
    add_row(0, 0, 1, ALPHA_SUB, 16'h0000, 24'h000000, 16'h0000, 1, 16'h0000);
    // source without flag passes through
    add_row(1, 0, 1, ALPHA_ADD, 16'h1234, 24'h000000, 16'h7fff, 1, 16'h1234);
    add_row(1, 0, 1, ALPHA_AVG, 16'hffff, 24'h000000, 16'hffff, 1, 16'hfbde);
    add_row(1, 0, 1, ALPHA_ADD, 16'hffff, 24'h000000, 16'hffff, 1, 16'hffff);
    add_row(1, 0, 1, ALPHA_SUB, 16'hffff, 24'h000000, 16'hffff, 1, 16'h8000);
    add_row(1, 0, 1, ALPHA_QTR, 16'hffff, 24'h000000, 16'hffff, 1, 16'hffff);
    add_row(1, 0, 1, ALPHA_AVG, 16'hffff, 24'h000000, 16'h0000, 1, 16'hbdef);
    add_row(1, 0, 1, ALPHA_ADD, 16'hffff, 24'h000000, 16'h0000, 1, 16'hffff);
    add_row(1, 0, 1, ALPHA_SUB, 16'hffff, 24'h000000, 16'h0000, 1, 16'h8000);
    add_row(1, 0, 1, ALPHA_QTR, 16'hffff, 24'h000000, 16'h0000, 1, 16'h9ce7);
    add_row(1, 0, 1, ALPHA_SUB, 16'h8000, 24'h000000, 16'hffff, 0, 16'h0000);
    add_row(0, 1, 1, ALPHA_AVG, 16'h0000, 24'ha5c3e7, 16'h5a5a, 0, 16'h0000);
    add_row(1, 1, 1, ALPHA_SUB, 16'h5555, 24'h123456, 16'haaaa, 0, 16'h0000);
    add_row(0, 1, 1, ALPHA_QTR, 16'h0000, 24'h000000, 16'h7fff, 0, 16'h0000);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (frag_rows[i]) begin
      if (frag_rows[i].typed) begin
        want = '0;
        want.pixel_out    = frag_rows[i].pix;
        want.write_enable = (frag_rows[i].pix != '0);
      end else begin
        want = blend_pixel(frag_rows[i].frag);
      end
      push_frag(frag_rows[i].frag, want, 1'b1);
    end

    for (int unsigned k = 0; k < NumRand; k++) begin
      if (k == HoldAt) hold_req = 1'b1;
      if (k == NumRand - QuietTail) quiet_on = 1'b1;
      f = rand_frag();
      push_frag(f, blend_pixel(f), k < NumRand - QuietTail);
    end
    s_axis_tvalid_i <= 1'b0;

    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
